// File: hdl/rhh_pkg.sv
// Package for the Robin Hood hash table.
// Slot states, operation kinds, result codes and controller command/status structs.
// No dependencies.
package rhh_pkg;

  localparam int KIND_W   = 2;
  localparam int BUCKET_W = 10;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_OCCUPIED = 2'd1;
  localparam logic [1:0] ST_DELETED  = 2'd2;

  localparam logic [STATUS_W-1:0] RES_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] RES_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] RES_FULL = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch request, start at home bucket
    logic advance;     // step index, bump carried distance
    logic swap;        // carried entry <-> slot entry
    logic wr_entry;    // write state/dist/key/value of carried entry
    logic wr_dv;       // write distance and value only (key match)
    logic wr_deleted;  // mark slot deleted
    logic set_result;  // capture status/found value
    logic [STATUS_W-1:0] res_status;
    logic res_hit;     // found value from slot read
  } rhh_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [1:0] slot_st;
    logic key_eq;       // slot key == carried key
    logic dist_gt;      // carried dist > slot dist
    logic dist_full;    // carried dist >= depth
  } rhh_stat_t;

endpackage

// File: hdl/rhh_if.sv
// Valid/ready channel interface.
// Depends on nothing; payload width set by parameters.
interface rhh_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: hdl/rhh_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: hdl/rhh_datapath.sv
// Datapath: slot memories, state valid/clear sweep, carried entry and result.
// Depends on rhh_pkg and rhh_ram.
module rhh_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  rhh_pkg::rhh_cmd_t             cmd,
  input  logic [rhh_pkg::KIND_W-1:0]    in_kind,
  input  logic [rhh_pkg::BUCKET_W-1:0]  in_home,
  input  logic [rhh_pkg::KEY_W-1:0]     in_key,
  input  logic [rhh_pkg::VAL_W-1:0]     in_value,
  input  logic                          clr_active,
  input  logic [$clog2(DEPTH)-1:0]      clr_addr,
  output rhh_pkg::rhh_stat_t            stat,
  output logic [rhh_pkg::STATUS_W-1:0]  res_status,
  output logic [rhh_pkg::VAL_W-1:0]     res_value
);
  import rhh_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int DW = $clog2(DEPTH) + 1;
  localparam int RECIP = (1 << 20) / DEPTH;

  logic [KIND_W-1:0] kind;
  logic [AW-1:0]     idx;
  logic [DW-1:0]     c_dist;
  logic [KEY_W-1:0]  c_key;
  logic [VAL_W-1:0]  c_val;

  logic [1:0]        st_rd;
  logic [DW-1:0]     d_rd;
  logic [KEY_W-1:0]  k_rd;
  logic [VAL_W-1:0]  v_rd;

  // Home bucket modulo depth: reciprocal multiply gives a quotient that is
  // at most one low, a single compare-subtract fixes the remainder
  logic [29:0]   q_prod;
  logic [26:0]   q_depth;
  logic [26:0]   rem;
  logic [AW-1:0] home_mod;
  always_comb begin
    q_prod   = 30'(in_home) * 30'(RECIP);
    q_depth  = 27'(q_prod[29:20]) * 27'(DEPTH);
    rem      = 27'(in_home) - q_depth;
    home_mod = (rem >= 27'(DEPTH)) ? AW'(rem - 27'(DEPTH)) : AW'(rem);
  end

  // Carried entry and probe index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind   <= in_kind;
      idx    <= home_mod;
      c_dist <= '0;
      c_key  <= in_key;
      c_val  <= in_value;
    end else begin
      if (cmd.swap) begin
        c_key <= k_rd;
        c_val <= v_rd;
      end
      if (cmd.advance) begin
        idx    <= (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
        c_dist <= (cmd.swap ? d_rd : c_dist) + 1'b1;
      end
    end
  end

  // Slot memories; state is written during the clearing sweep
  logic st_we;
  logic [AW-1:0] st_addr;
  logic [1:0] st_wd;
  assign st_we   = clr_active | cmd.wr_entry | cmd.wr_deleted;
  assign st_addr = clr_active ? clr_addr : idx;
  assign st_wd   = clr_active ? ST_EMPTY : (cmd.wr_deleted ? ST_DELETED : ST_OCCUPIED);

  rhh_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_state (
    .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wd), .rdata(st_rd));
  rhh_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dist (
    .clk(clk), .we(cmd.wr_entry | cmd.wr_dv), .addr(idx), .wdata(c_dist), .rdata(d_rd));
  rhh_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key (
    .clk(clk), .we(cmd.wr_entry), .addr(idx), .wdata(c_key), .rdata(k_rd));
  rhh_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_val (
    .clk(clk), .we(cmd.wr_entry | cmd.wr_dv), .addr(idx), .wdata(c_val), .rdata(v_rd));

  // Compare results for the controller
  assign stat.kind      = kind;
  assign stat.slot_st   = st_rd;
  assign stat.key_eq    = (k_rd == c_key);
  assign stat.dist_gt   = (c_dist > d_rd);
  assign stat.dist_full = (c_dist >= DW'(DEPTH));

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_status <= cmd.res_status;
      res_value  <= cmd.res_hit ? v_rd : '0;
    end
  end
endmodule

// File: hdl/rhh_ctrl.sv
// Controller FSM: clearing sweep, probe sequencing, result handshake.
// Depends on rhh_pkg.
module rhh_ctrl #(
  parameter int DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  rhh_pkg::rhh_stat_t        stat,
  output rhh_pkg::rhh_cmd_t         cmd,
  output logic                      clr_active,
  output logic [$clog2(DEPTH)-1:0]  clr_addr
);
  import rhh_pkg::*;

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [AW-1:0] clr_cnt;
  logic out_pend;

  assign clr_active = (state == S_CLEAR);
  assign clr_addr   = clr_cnt;
  // Accept a new request once the previous result slot is free
  assign in_ready   = (state == S_IDLE) && !out_pend;
  assign out_valid  = out_pend;

  always_comb begin
    cmd = '0;
    cmd.res_status = RES_MISS;
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load = 1'b1;
        state_next = S_READ;
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        state_next = S_READ;
        if (stat.kind == KIND_INSERT) begin
          if (stat.slot_st != ST_OCCUPIED) begin
            cmd.wr_entry = 1'b1; cmd.set_result = 1'b1; cmd.res_status = RES_OK;
            state_next = S_OUT;
          end else if (stat.dist_full) begin
            cmd.set_result = 1'b1; cmd.res_status = RES_FULL;
            state_next = S_OUT;
          end else if (stat.key_eq) begin
            cmd.wr_dv = 1'b1; cmd.set_result = 1'b1; cmd.res_status = RES_OK;
            state_next = S_OUT;
          end else begin
            cmd.advance = 1'b1;
            if (stat.dist_gt) begin
              cmd.wr_entry = 1'b1; cmd.swap = 1'b1;
            end
          end
        end else if (stat.kind == KIND_LOOKUP || stat.kind == KIND_REMOVE) begin
          // dist_full is checked first: probe bound reached
          if (stat.dist_full || stat.slot_st == ST_EMPTY ||
              (stat.slot_st == ST_OCCUPIED && stat.dist_gt)) begin
            cmd.set_result = 1'b1; cmd.res_status = RES_MISS;
            state_next = S_OUT;
          end else if (stat.slot_st == ST_OCCUPIED && stat.key_eq) begin
            cmd.set_result = 1'b1; cmd.res_status = RES_OK;
            cmd.res_hit = (stat.kind == KIND_LOOKUP);
            cmd.wr_deleted = (stat.kind == KIND_REMOVE);
            state_next = S_OUT;
          end else begin
            cmd.advance = 1'b1;
          end
        end else begin
          cmd.set_result = 1'b1; cmd.res_status = RES_MISS;
          state_next = S_OUT;
        end
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      out_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_OUT) out_pend <= 1'b1;
      else if (out_valid && out_ready) out_pend <= 1'b0;
    end
  end
endmodule

// File: hdl/robin_hood_hash_table.sv
// Robin Hood hash table, linear probing with tombstones.
// Each probed slot is read and then evaluated, and the result is registered
// in a result state before it is offered; the single-port slot memories set
// the pace. One request is worked at a time: no new request is accepted until
// the result has been taken by the sink. Reset: synchronous; a clearing sweep
// marks all slots empty, during which no request is accepted.
module robin_hood_hash_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic clk,
  input  logic rst,
  rhh_if.sink   in_ch,
  rhh_if.source out_ch
);
  import rhh_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  rhh_cmd_t  cmd;
  rhh_stat_t stat;
  logic clr_active;
  logic [AW-1:0] clr_addr;
  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0] res_value;

  rhh_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd), .clr_active(clr_active), .clr_addr(clr_addr));

  rhh_datapath #(.DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .cmd(cmd),
    .in_kind(in_ch.data[KIND_W+BUCKET_W+2*KEY_W-1 -: KIND_W]),
    .in_home(in_ch.data[BUCKET_W+2*KEY_W-1 -: BUCKET_W]),
    .in_key(in_ch.data[2*KEY_W-1 -: KEY_W]),
    .in_value(in_ch.data[VAL_W-1:0]),
    .clr_active(clr_active), .clr_addr(clr_addr),
    .stat(stat), .res_status(res_status), .res_value(res_value));

  assign out_ch.data = {res_status, res_value};

  // No request accepted during the clearing sweep
  a_no_accept_clr: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !in_ch.ready) else $error("accept during clear");
  // Output holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  // Not ready for input while a result is pending
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("accept with result pending");
endmodule
